@@ design/mra_pkg.sv @@
// shared widths, reset values and defaults for the meeting room allocator
package mra_pkg;

  localparam int unsigned RoomW  = 7;
  localparam int unsigned IdW    = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned LimitW = 7;

  // wide enough to compare the room limit with any room count up to 1024
  localparam int unsigned CmpW = 11;
  // working width of the meeting id reduction (ids times the largest table)
  localparam int unsigned ModW = 20;

  localparam logic [LimitW-1:0] RoomLimitReset = 7'd64;

  localparam int unsigned MeetingsDefault = 256;
  localparam int unsigned RoomsDefault    = 64;

endpackage

@@ design/mra_room_table.sv @@
// room table: synchronous memory with one read and one write port, holding the room of each meeting
module mra_room_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DW    = 7
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DW-1:0]            rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DW-1:0]            wr_data_i
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

@@ design/mra_free_list.sv @@
// free room fifo: memory with head and tail pointers and a fill count
module mra_free_list #(
  parameter int unsigned ROOMS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  output logic [$clog2(ROOMS+1)-1:0] rd_data_o,
  input  logic                       pop_i,
  input  logic                       push_i,
  input  logic [$clog2(ROOMS+1)-1:0] push_data_i,
  output logic [$clog2(ROOMS+1)-1:0] count_o
);

  localparam int unsigned DW = $clog2(ROOMS + 1);
  localparam int unsigned PW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam logic [PW-1:0] LastPtr = PW'(ROOMS - 1);
  localparam logic [DW-1:0] Full    = DW'(ROOMS);

  logic [DW-1:0] mem [ROOMS];
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [DW-1:0] count_q, count_d;
  logic          push_ok;

  // a room freed into a full list is dropped
  assign push_ok = push_i && (count_q != Full);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop_i) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
    end
    if (push_ok) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
    end
    if (pop_i && !push_ok) begin
      count_d = count_q - 1'b1;
    end else if (push_ok && !pop_i) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[head_q];
    end
  end

  assign count_o = count_q;

endmodule

@@ design/meeting_room_allocator.sv @@
// meeting room allocator: event control, room counters and result register
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o    is_start_i meeting_id_i event_time_i
//   out      output     out_valid_o/out_ready_i  room_o opened_new_o status_o
//                                                rooms_peak_o peak_time_o
//   cfg      input      cfg_we_i                 cfg_wdata_i (room limit)
//
// the transfer edge of an event reads the room table and the head of the
// free fifo; the write-back edge updates both memories and loads the
// result register, so one event occupies the memory ports at a time.
// a finished result waits in the output register while the next event is
// taken; the write-back stage holds while that register is full and stalled.
// reset clears all counters and pointers; the memories need no clearing.
module meeting_room_allocator #(
  parameter int unsigned MEETINGS = mra_pkg::MeetingsDefault,
  parameter int unsigned ROOMS    = mra_pkg::RoomsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mra_pkg::LimitW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          is_start_i,
  input  logic [mra_pkg::IdW-1:0]       meeting_id_i,
  input  logic [mra_pkg::TimeW-1:0]     event_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mra_pkg::RoomW-1:0]     room_o,
  output logic                          opened_new_o,
  output logic                          status_o,
  output logic [mra_pkg::RoomW-1:0]     rooms_peak_o,
  output logic [mra_pkg::TimeW-1:0]     peak_time_o
);

  import mra_pkg::*;

  localparam int unsigned RW = $clog2(ROOMS + 1);
  localparam int unsigned IW = $clog2(MEETINGS);

  logic [LimitW-1:0] room_limit_q;
  logic              busy_q;
  logic              ev_start_q;
  logic [IW-1:0]     ev_idx_q;
  logic [TimeW-1:0]  ev_time_q;
  logic [RW-1:0]     opened_q, opened_d;
  logic [TimeW-1:0]  peak_q, peak_d;

  logic              out_valid_q;
  logic [RoomW-1:0]  room_q;
  logic              opened_new_q;
  logic              status_q;
  logic [RoomW-1:0]  rooms_peak_q;
  logic [TimeW-1:0]  peak_time_q;

  logic              in_fire;
  logic              wb_fire;
  logic [ModW-1:0]   id_rem;
  logic [IW-1:0]     id_idx;
  logic [CmpW-1:0]   limit;

  logic [RW-1:0]     tbl_rd_data;
  logic              tbl_wr_en;
  logic [RW-1:0]     tbl_wr_data;
  logic [RW-1:0]     fl_rd_data;
  logic [RW-1:0]     fl_count;
  logic              fl_pop;
  logic              fl_push;

  logic [RW-1:0]     room_res;
  logic              opened_res;
  logic              status_res;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign wb_fire    = busy_q && (!out_valid_q || out_ready_i);

  // meeting id modulo the table depth, by conditional subtraction
  always_comb begin
    id_rem = ModW'(meeting_id_i);
    for (int k = IdW - 1; k >= 0; k--) begin
      if (id_rem >= (ModW'(MEETINGS) << k)) begin
        id_rem = id_rem - (ModW'(MEETINGS) << k);
      end
    end
    id_idx = id_rem[IW-1:0];
  end

  assign limit = (CmpW'(room_limit_q) < CmpW'(ROOMS)) ? CmpW'(room_limit_q) : CmpW'(ROOMS);

  // resolve the event from the memory read data
  always_comb begin
    room_res    = '0;
    opened_res  = 1'b0;
    status_res  = 1'b0;
    opened_d    = opened_q;
    peak_d      = peak_q;
    fl_pop      = 1'b0;
    fl_push     = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_wr_data = '0;
    if (ev_start_q) begin
      if (fl_count != '0) begin
        room_res = fl_rd_data;
        fl_pop   = wb_fire;
      end else if (CmpW'(opened_q) < limit) begin
        opened_d   = opened_q + 1'b1;
        room_res   = opened_d;
        peak_d     = ev_time_q;
        opened_res = 1'b1;
      end else begin
        status_res = 1'b1;
      end
      tbl_wr_en   = wb_fire;
      tbl_wr_data = room_res;
    end else begin
      room_res = tbl_rd_data;
      if (tbl_rd_data != '0) begin
        fl_push   = wb_fire;
        tbl_wr_en = wb_fire;
      end
    end
  end

  mra_room_table #(
    .DEPTH (MEETINGS),
    .DW    (RW)
  ) u_room_table (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (id_idx),
    .rd_data_o (tbl_rd_data),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (ev_idx_q),
    .wr_data_i (tbl_wr_data)
  );

  mra_free_list #(
    .ROOMS (ROOMS)
  ) u_free_list (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_fire),
    .rd_data_o   (fl_rd_data),
    .pop_i       (fl_pop),
    .push_i      (fl_push),
    .push_data_i (tbl_rd_data),
    .count_o     (fl_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_limit_q <= RoomLimitReset;
      busy_q       <= 1'b0;
      opened_q     <= '0;
      peak_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        room_limit_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (wb_fire) begin
        busy_q <= 1'b0;
      end
      if (wb_fire) begin
        opened_q    <= opened_d;
        peak_q      <= peak_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // event fields held for the write-back cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_start_q <= is_start_i;
      ev_idx_q   <= id_idx;
      ev_time_q  <= event_time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      room_q       <= RoomW'(room_res);
      opened_new_q <= opened_res;
      status_q     <= status_res;
      rooms_peak_q <= RoomW'(opened_d);
      peak_time_q  <= peak_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign room_o       = room_q;
  assign opened_new_o = opened_new_q;
  assign status_o     = status_q;
  assign rooms_peak_o = rooms_peak_q;
  assign peak_time_o  = peak_time_q;

  a_one_event_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("event taken while another was in write-back");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q))
    else $error("result appeared with no event in write-back");

  a_opened_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(opened_q) <= CmpW'(ROOMS))
    else $error("opened room count beyond room capacity");

  a_flag_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(status_o && opened_new_o))
    else $error("start both refused and given a new room");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the meeting room allocator, with a room allocation predictor
module tb;
  import mra_pkg::*;

  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned PhaseItems = 107;
  localparam int unsigned Phases     = 7;
  localparam int unsigned SpareW     = $clog2(RoomsDefault);

  localparam logic EvEnd    = 1'b0;
  localparam logic EvStart  = 1'b1;
  localparam logic StOk     = 1'b0;
  localparam logic StNoRoom = 1'b1;

  // room limit and start bias (percent) of each random phase
  localparam logic [Phases*LimitW-1:0] PhaseLimits =
    {7'd127, 7'd0, 7'd64, 7'd40, 7'd1, 7'd8, 7'd127};
  localparam logic [Phases*8-1:0] PhaseBias =
    {8'd40, 8'd45, 8'd85, 8'd55, 8'd50, 8'd55, 8'd60};

  typedef enum logic {RowEvent, RowLimit} row_kind_e;

  typedef struct packed {
    logic [RoomW-1:0] room;
    logic             opened_new;
    logic             status;
    logic [RoomW-1:0] rooms_peak;
    logic [TimeW-1:0] peak_time;
  } alloc_t;

  typedef struct packed {
    row_kind_e         kind;
    logic              is_start;
    logic [IdW-1:0]    id;
    logic [TimeW-1:0]  stamp;
    logic [LimitW-1:0] limit;
    logic              typed;
    alloc_t            want;
  } step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [LimitW-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              is_start = 1'b0;
  logic [IdW-1:0]    meeting_id = '0;
  logic [TimeW-1:0]  event_time = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RoomW-1:0]  room;
  logic              opened_new;
  logic              status;
  logic [RoomW-1:0]  rooms_peak;
  logic [TimeW-1:0]  peak_time;

  // typed expectation, travels with the payload of its transfer
  logic   want_typed = 1'b0;
  alloc_t want_alloc = '0;

  // predictor state
  logic [LimitW-1:0] limit_now = RoomLimitReset;
  logic [RoomW-1:0]  held_room [MeetingsDefault];
  logic [RoomW-1:0]  spare_room [RoomsDefault];
  logic [SpareW-1:0] spare_head = '0;
  logic [SpareW-1:0] spare_tail = '0;
  logic [RoomW-1:0]  spare_count = '0;
  logic [RoomW-1:0]  rooms_open = '0;
  logic [TimeW-1:0]  last_open_time = '0;

  alloc_t      expected_allocs[$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  // stimulus bookkeeping
  logic [MeetingsDefault-1:0] ever_started = '0;
  logic [MeetingsDefault-1:0] running = '0;
  logic [IdW-1:0]             running_ids[$];
  int unsigned                eager_left = 0;
  step_t                      script[$];

  meeting_room_allocator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .is_start_i   (is_start),
    .meeting_id_i (meeting_id),
    .event_time_i (event_time),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .room_o       (room),
    .opened_new_o (opened_new),
    .status_o     (status),
    .rooms_peak_o (rooms_peak),
    .peak_time_o  (peak_time)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  function automatic alloc_t allot_room(input logic start, input logic [IdW-1:0] id,
                                        input logic [TimeW-1:0] stamp);
    alloc_t      r;
    int unsigned cap;
    r = '0;
    cap = (limit_now < RoomsDefault) ? limit_now : RoomsDefault;
    if (start == EvStart) begin
      if (spare_count != 0) begin
        r.room = spare_room[spare_head];
        spare_head = spare_head + 1'b1;
        spare_count = spare_count - 1'b1;
      end else if (rooms_open < cap) begin
        rooms_open = rooms_open + 1'b1;
        r.room = rooms_open;
        r.opened_new = 1'b1;
        last_open_time = stamp;
      end else begin
        r.status = StNoRoom;
      end
      held_room[id] = r.room;
    end else begin
      r.room = held_room[id];
      if (r.room != 0) begin
        // a full free list drops the room
        if (spare_count < RoomsDefault) begin
          spare_room[spare_tail] = r.room;
          spare_tail = spare_tail + 1'b1;
          spare_count = spare_count + 1'b1;
        end
        held_room[id] = '0;
      end
    end
    r.rooms_peak = rooms_open;
    r.peak_time = last_open_time;
    return r;
  endfunction

  always @(posedge clk) begin : predict_on_transfer
    alloc_t got;
    if (rst_n && in_valid && in_ready) begin
      got = allot_room(is_start, meeting_id, event_time);
      expected_allocs.push_back(want_typed ? want_alloc : got);
    end
  end

  always @(posedge clk) begin : check_results
    alloc_t oldest;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_allocs.size() == 0) begin
        $error("unexpected result: room %0d", room);
        mismatches++;
      end else begin
        oldest = expected_allocs.pop_front();
        if (room !== oldest.room) begin
          $error("room: expected %0d, got %0d", oldest.room, room);
          mismatches++;
        end
        if (opened_new !== oldest.opened_new) begin
          $error("opened_new: expected %0d, got %0d", oldest.opened_new, opened_new);
          mismatches++;
        end
        if (status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status);
          mismatches++;
        end
        if (rooms_peak !== oldest.rooms_peak) begin
          $error("rooms_peak: expected %0d, got %0d", oldest.rooms_peak, rooms_peak);
          mismatches++;
        end
        if (peak_time !== oldest.peak_time) begin
          $error("peak_time: expected %0d, got %0d", oldest.peak_time, peak_time);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_stalls
    int unsigned roll;
    forever begin
      roll = $urandom_range(0, 99);
      out_ready <= 1'b1;
      if (roll < 8) repeat ($urandom_range(30, 90)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll >= 40) begin
        out_ready <= 1'b0;
        if (roll < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StuckLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic plan_event(input logic start, input logic [IdW-1:0] id,
                            input logic [TimeW-1:0] stamp);
    step_t s;
    s = '0;
    s.kind = RowEvent;
    s.is_start = start;
    s.id = id;
    s.stamp = stamp;
    script.push_back(s);
  endtask

  task automatic plan_checked(input logic start, input logic [IdW-1:0] id,
                              input logic [TimeW-1:0] stamp, input logic [RoomW-1:0] rm,
                              input logic opened, input logic stat,
                              input logic [RoomW-1:0] peak, input logic [TimeW-1:0] ptime);
    step_t s;
    s = '0;
    s.kind = RowEvent;
    s.is_start = start;
    s.id = id;
    s.stamp = stamp;
    s.typed = 1'b1;
    s.want.room = rm;
    s.want.opened_new = opened;
    s.want.status = stat;
    s.want.rooms_peak = peak;
    s.want.peak_time = ptime;
    script.push_back(s);
  endtask

  task automatic plan_limit(input logic [LimitW-1:0] value);
    step_t s;
    s = '0;
    s.kind = RowLimit;
    s.limit = value;
    script.push_back(s);
  endtask

  task automatic send_item(input logic start, input logic [IdW-1:0] id,
                           input logic [TimeW-1:0] stamp, input logic typed, input alloc_t want);
    int unsigned gap;
    int unsigned roll;
    int          hit;
    roll = $urandom_range(0, 99);
    if (eager_left > 0) begin
      gap = 0;
      eager_left--;
    end else if (roll < 55) begin
      gap = 0;
    end else if (roll < 88) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
    // now and then a run of back-to-back transfers
    if (roll == 0) eager_left = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    is_start   <= start;
    meeting_id <= id;
    event_time <= stamp;
    want_typed <= typed;
    want_alloc <= want;
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
    hit = -1;
    if (start == EvStart) begin
      ever_started[id] = 1'b1;
      if (!running[id]) begin
        running[id] = 1'b1;
        running_ids.push_back(id);
      end
    end else if (running[id]) begin
      running[id] = 1'b0;
      for (int k = 0; k < running_ids.size(); k++) if (running_ids[k] == id) hit = k;
      if (hit >= 0) running_ids.delete(hit);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LimitW-1:0] value);
    wait_for_results();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = value;
  endtask

  initial begin : stimulus
    logic             st;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] stamp;
    logic [TimeW-1:0] clock_now;
    int unsigned      roll;
    int unsigned      pick;
    int unsigned      tries;

    plan_checked(EvStart, 8'd0,   16'd0,     7'd1, 1'b1, StOk,     7'd1, 16'd0);
    plan_event  (EvStart, 8'd255, 16'd5);
    plan_event  (EvEnd,   8'd0,   16'd7);
    // repeated end frees nothing
    plan_checked(EvEnd,   8'd0,   16'd7,     7'd0, 1'b0, StOk,     7'd2, 16'd5);
    plan_event  (EvStart, 8'd1,   16'd9);
    plan_event  (EvStart, 8'd1,   16'd9);
    plan_event  (EvEnd,   8'd1,   16'd10);
    plan_event  (EvEnd,   8'd255, 16'd10);
    // oldest freed room first
    plan_event  (EvStart, 8'd128, 16'd12);
    plan_event  (EvStart, 8'd170, 16'd12);
    plan_limit  (7'd3);
    plan_checked(EvStart, 8'd85,  16'd20,    7'd0, 1'b0, StNoRoom, 7'd3, 16'd9);
    plan_checked(EvEnd,   8'd85,  16'd21,    7'd0, 1'b0, StOk,     7'd3, 16'd9);
    plan_limit  (7'd0);
    plan_event  (EvEnd,   8'd128, 16'd22);
    plan_event  (EvStart, 8'd200, 16'd23);
    plan_checked(EvStart, 8'd201, 16'd23,    7'd0, 1'b0, StNoRoom, 7'd3, 16'd9);
    // above the room count acts as the room count
    plan_limit  (7'd127);
    plan_checked(EvStart, 8'd202, 16'hFFFF,  7'd4, 1'b1, StOk,     7'd4, 16'hFFFF);
    plan_event  (EvEnd,   8'd170, 16'hFFFF);
    plan_event  (EvStart, 8'd203, 16'hFFFF);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == RowLimit) set_limit(script[i].limit);
      else send_item(script[i].is_start, script[i].id, script[i].stamp, script[i].typed,
                     script[i].want);
    end

    clock_now = TimeW'($urandom);
    for (int p = 0; p < Phases; p++) begin
      set_limit(PhaseLimits[p*LimitW +: LimitW]);
      for (int n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          if (running_ids.size() == 0 || $urandom_range(0, 99) < PhaseBias[p*8 +: 8]) begin
            st = EvStart;
            id = IdW'($urandom_range(0, 255));
            tries = 0;
            // mostly fresh meetings, a repeated start now and then
            while (running[id] && tries < 8 && roll > 4) begin
              id = IdW'($urandom_range(0, 255));
              tries++;
            end
          end else begin
            st = EvEnd;
            pick = $urandom_range(0, running_ids.size() - 1);
            id = running_ids[pick];
          end
          if ($urandom_range(0, 49) == 0) clock_now = clock_now + TimeW'($urandom);
          else clock_now = clock_now + TimeW'($urandom_range(0, 3));
          stamp = clock_now;
        end else begin
          st = 1'($urandom_range(0, 1));
          id = IdW'($urandom_range(0, 255));
          // never end a meeting whose table entry was never written
          if (st == EvEnd && !ever_started[id]) st = EvStart;
          stamp = TimeW'($urandom);
        end
        send_item(st, id, stamp, 1'b0, '0);
        if ($urandom_range(0, 79) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (expected_allocs.size() != 0) begin
      $error("%0d expected results never arrived", expected_allocs.size());
      mismatches++;
    end
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
design/mra_pkg.sv
design/mra_room_table.sv
design/mra_free_list.sv
design/meeting_room_allocator.sv
tb/tb.sv
